// ===== rtl/fpti_pkg.sv =====
// Shared types, constants and command codes of the four point table interpolator.
// Used by every module of the block but fpti_ram; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package fpti_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 256;

   localparam int DATA_W  = 32;
   localparam int ENTRY_W = 8;
   localparam int CSR_W   = 9;

   localparam logic [CSR_W-1:0] TABLE_SIZE_RESET   = 9'd4;
   localparam logic [CSR_W-1:0] LAST_BRACKET_RESET = 9'd1;
   localparam int MIN_TABLE_SIZE = 4;
   localparam int POINTS         = 4;

   // Exact term arithmetic: |y| * three key differences, over three differences.
   localparam int MUL_STEPS = DATA_W;
   localparam int NUM_W     = 4 * DATA_W;
   localparam int DEN_W     = 3 * DATA_W;
   localparam int DVD_W     = NUM_W + 1;
   localparam int DVS_W     = DEN_W + 1;
   localparam int ACC_W     = DVD_W + 3;
   localparam int CNT_W     = 8;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic                     req_type;
      logic [ENTRY_W-1:0]       entry_index;
      logic signed [DATA_W-1:0] key_value;
      logic signed [DATA_W-1:0] entry_value;
   } req_item_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] result_value;
      logic [CSR_W-1:0]         bracket_index;
      logic                     overflow_flag;
   } rsp_item_type;

   typedef enum logic [4:0] {
      S_IDLE, S_RD1, S_RDN, S_ASC, S_H0_CHK, S_HUP_RD, S_HUP_CHK, S_HDN_RD, S_HDN_CHK,
      S_BIS, S_BIS_CHK, S_DONE, S_FETCH, S_PREP, S_TINIT, S_FINIT, S_MUL, S_DIVI,
      S_DIV, S_ACC, S_OUT
   } ctrl_state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_CAPTURE, OP_KEY1, OP_ASC, OP_HUP_START, OP_HDN_START,
      OP_HUP_STEP, OP_HDN_STEP, OP_SET_ZERO, OP_BIS_STEP, OP_BRACKET, OP_FETCH,
      OP_NUDGE, OP_TERM_INIT, OP_FACTOR_INIT, OP_MUL_STEP, OP_DIV_INIT, OP_DIV_STEP,
      OP_ACCUM, OP_OUT_LOAD
   } dp_op_type;

   typedef enum logic [2:0] {
      ADDR_FIRST, ADDR_LAST, ADDR_LO, ADDR_HI, ADDR_MID, ADDR_FETCH
   } addr_sel_type;

   typedef struct packed {
      dp_op_type    op;
      addr_sel_type addr_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic stale;
      logic hunt_up;
      logic hunt_dn;
      logic bis_right;
      logic lo_is_n;
      logic lo_is_one;
      logic hup_over;
      logic hdn_under;
      logic bis_done;
      logic fetch_done;
      logic zero_den;
      logic mul_last;
      logic factor_last;
      logic div_last;
      logic term_last;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== rtl/fpti_ram.sv =====
// Generic single write, single read RAM with a registered read port.
// Stands alone; used for the key and value tables.
`timescale 1ns / 1ps
`default_nettype none

module fpti_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/fpti_ctrl.sv =====
// Controller state machine: sequences the search, the fetch and the four term evaluations.
// Depends on fpti_pkg; drives the datapath by command and reads its status.
`timescale 1ns / 1ps
`default_nettype none

module fpti_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic                    req_kind,
   output logic                         req_stall,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   input  wire fpti_pkg::dp_status_type status,
   output fpti_pkg::dp_cmd_type         cmd
);
   import fpti_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_free;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd.op       = OP_NONE;
      cmd.addr_sel = ADDR_LO;
      req_stall    = 1'b1;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_kind == REQ_LOAD) begin
                  cmd.op = OP_LOAD;
               end else begin
                  cmd.op   = OP_CAPTURE;
                  state_in = S_RD1;
               end
            end
         end
         S_RD1: begin
            cmd.addr_sel = ADDR_FIRST;
            state_in     = S_RDN;
         end
         S_RDN: begin
            cmd.addr_sel = ADDR_LAST;
            cmd.op       = OP_KEY1;
            state_in     = S_ASC;
         end
         S_ASC: begin
            cmd.addr_sel = ADDR_LO;
            cmd.op       = OP_ASC;
            state_in     = status.stale ? S_BIS : S_H0_CHK;
         end
         S_H0_CHK: begin
            if (status.hunt_up) begin
               if (status.lo_is_n) begin
                  state_in = S_DONE;
               end else begin
                  cmd.op   = OP_HUP_START;
                  state_in = S_HUP_RD;
               end
            end else if (status.lo_is_one) begin
               cmd.op   = OP_SET_ZERO;
               state_in = S_DONE;
            end else begin
               cmd.op   = OP_HDN_START;
               state_in = S_HDN_RD;
            end
         end
         S_HUP_RD: begin
            cmd.addr_sel = ADDR_HI;
            state_in     = S_HUP_CHK;
         end
         S_HUP_CHK: begin
            if (status.hunt_up) begin
               cmd.op   = OP_HUP_STEP;
               state_in = status.hup_over ? S_BIS : S_HUP_RD;
            end else begin
               state_in = S_BIS;
            end
         end
         S_HDN_RD: begin
            cmd.addr_sel = ADDR_LO;
            state_in     = S_HDN_CHK;
         end
         S_HDN_CHK: begin
            if (status.hunt_dn) begin
               cmd.op   = OP_HDN_STEP;
               state_in = status.hdn_under ? S_BIS : S_HDN_RD;
            end else begin
               state_in = S_BIS;
            end
         end
         S_BIS: begin
            if (status.bis_done) begin
               state_in = S_DONE;
            end else begin
               cmd.addr_sel = ADDR_MID;
               state_in     = S_BIS_CHK;
            end
         end
         S_BIS_CHK: begin
            cmd.op   = OP_BIS_STEP;
            state_in = S_BIS;
         end
         S_DONE: begin
            cmd.op   = OP_BRACKET;
            state_in = S_FETCH;
         end
         S_FETCH: begin
            cmd.addr_sel = ADDR_FETCH;
            cmd.op       = OP_FETCH;
            if (status.fetch_done) begin
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            cmd.op   = OP_NUDGE;
            state_in = status.zero_den ? S_OUT : S_TINIT;
         end
         S_TINIT: begin
            cmd.op   = OP_TERM_INIT;
            state_in = S_FINIT;
         end
         S_FINIT: begin
            cmd.op   = OP_FACTOR_INIT;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.op = OP_MUL_STEP;
            if (status.mul_last) begin
               state_in = status.factor_last ? S_DIVI : S_FINIT;
            end
         end
         S_DIVI: begin
            cmd.op   = OP_DIV_INIT;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = OP_DIV_STEP;
            if (status.div_last) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            cmd.op   = OP_ACCUM;
            state_in = status.term_last ? S_OUT : S_TINIT;
         end
         S_OUT: begin
            if (rsp_free) begin
               cmd.op       = OP_OUT_LOAD;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   a_out_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && rsp_free) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("finished query did not reach the result register");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_OUT))
      else $error("result raised outside the output state");

   a_load_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid && req_kind == REQ_LOAD) |=> (state_ff == S_IDLE))
      else $error("load item started a query sequence");

endmodule

`default_nettype wire

// ===== rtl/fpti_dp.sv =====
// Datapath: table RAMs, search registers, bit-serial multiplier, restoring divider.
// Depends on fpti_pkg and fpti_ram; obeys commands from fpti_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module fpti_dp #(
   parameter int TABLE_DEPTH = fpti_pkg::DEFAULT_TABLE_DEPTH
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire fpti_pkg::dp_cmd_type      cmd,
   input  wire fpti_pkg::req_item_type    req_item,
   input  wire logic                      csr_wr_en,
   input  wire logic [fpti_pkg::CSR_W-1:0] csr_wr_data,
   output fpti_pkg::dp_status_type        status,
   output fpti_pkg::rsp_item_type         rsp_item
);
   import fpti_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int IW = ((AW > CSR_W) ? AW : CSR_W) + 3;
   localparam logic signed [IW-1:0] DEPTH_I = IW'(TABLE_DEPTH);
   localparam logic signed [IW-1:0] MIN_I   = IW'(MIN_TABLE_SIZE);
   localparam logic signed [IW-1:0] ONE_I   = IW'(1);
   localparam logic signed [IW-1:0] THREE_I = IW'(3);

   logic [CSR_W-1:0] table_size_ff, table_size_in;
   logic [CSR_W-1:0] last_bracket_ff, last_bracket_in;
   logic [CSR_W-1:0] bracket_ff, bracket_in;

   logic signed [DATA_W-1:0] xb_ff, xb_in, key1_ff, key1_in, xi_ff, xi_in;
   logic signed [IW-1:0] n_ff, n_in, lo_ff, lo_in, hi_ff, hi_in;
   logic signed [IW-1:0] inc_ff, inc_in, k_ff, k_in;
   logic asc_ff, asc_in, zd_ff, zd_in, neg_ff, neg_in;
   logic signed [DATA_W-1:0] xs_ff [POINTS];
   logic signed [DATA_W-1:0] xs_in [POINTS];
   logic signed [DATA_W-1:0] ys_ff [POINTS];
   logic signed [DATA_W-1:0] ys_in [POINTS];
   logic [1:0] term_ff, term_in, fac_ff, fac_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] num_ff, num_in, pn_ff, pn_in;
   logic [DEN_W-1:0] den_ff, den_in, pd_ff, pd_in;
   logic [DATA_W-1:0] fa_ff, fa_in, fb_ff, fb_in;
   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   rsp_item_type rsp_ff, rsp_in;

   logic [DATA_W-1:0] rd_key_raw, rd_val_raw;
   logic signed [DATA_W-1:0] rd_key, rd_val;
   logic [AW-1:0] rd_addr, wr_addr;
   logic wr_en;

   logic signed [IW-1:0] size_ext, n_clamp, mid, hup_next, hdn_next, addr_val, addr_m1;
   logic signed [IW-1:0] load_idx, k_raw, cnt_ext;
   logic ge, gt, key_match, zero_den, sat_fit, sat_sign;
   logic [1:0] fac_j, sel_idx;
   logic signed [DATA_W-1:0] xsel, ysel, res_sat;
   logic signed [DATA_W:0] da, db;
   logic [DATA_W-1:0] mag_a, mag_b, mag_y;
   logic [DVS_W:0] rem_sh, rem_diff;
   logic [ACC_W-1:0] q_ext;

   fpti_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(req_item.key_value),
      .rd_addr(rd_addr), .rd_data(rd_key_raw));

   fpti_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_val_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(req_item.entry_value),
      .rd_addr(rd_addr), .rd_data(rd_val_raw));

   assign rd_key = $signed(rd_key_raw);
   assign rd_val = $signed(rd_val_raw);

   // Load port.
   assign load_idx = $signed({{(IW-ENTRY_W){1'b0}}, req_item.entry_index});
   assign wr_en    = (cmd.op == OP_LOAD) && (load_idx < DEPTH_I);
   assign wr_addr  = load_idx[AW-1:0];

   // Search arithmetic.
   assign size_ext = $signed({{(IW-CSR_W){1'b0}}, table_size_ff});
   assign n_clamp  = (size_ext > DEPTH_I) ? DEPTH_I : ((size_ext < MIN_I) ? MIN_I : size_ext);
   assign ge       = xb_ff >= rd_key;
   assign gt       = xb_ff > rd_key;
   assign mid      = (hi_ff + lo_ff) >>> 1;
   assign hup_next = hi_ff + (inc_ff <<< 1);
   assign hdn_next = lo_ff - (inc_ff <<< 1);
   assign k_raw    = lo_ff - ONE_I;
   assign cnt_ext  = $signed({{(IW-CNT_W){1'b0}}, cnt_ff});

   always_comb begin
      case (cmd.addr_sel)
         ADDR_FIRST: addr_val = ONE_I;
         ADDR_LAST:  addr_val = n_ff;
         ADDR_LO:    addr_val = lo_ff;
         ADDR_HI:    addr_val = hi_ff;
         ADDR_MID:   addr_val = mid;
         ADDR_FETCH: addr_val = k_ff + cnt_ext;
         default:    addr_val = lo_ff;
      endcase
   end

   assign addr_m1 = addr_val - ONE_I;
   assign rd_addr = addr_m1[AW-1:0];

   // Term arithmetic.
   assign fac_j   = fac_ff + {1'b0, (fac_ff >= term_ff)};
   assign sel_idx = (cmd.op == OP_TERM_INIT) ? term_ff : fac_j;
   assign xsel    = xs_ff[sel_idx];
   assign ysel    = ys_ff[term_ff];
   assign da      = {xb_ff[DATA_W-1], xb_ff} - {xsel[DATA_W-1], xsel};
   assign db      = {xi_ff[DATA_W-1], xi_ff} - {xsel[DATA_W-1], xsel};
   assign mag_a   = da[DATA_W] ? DATA_W'(-da) : da[DATA_W-1:0];
   assign mag_b   = db[DATA_W] ? DATA_W'(-db) : db[DATA_W-1:0];
   assign mag_y   = ysel[DATA_W-1] ? DATA_W'(-ysel) : ysel;

   assign rem_sh   = {rem_ff, dvd_ff[DVD_W-1]};
   assign rem_diff = rem_sh - {1'b0, dvs_ff};
   assign q_ext    = ACC_W'(dvd_ff);

   always_comb begin
      key_match = 1'b0;
      zero_den  = 1'b0;
      for (int p = 0; p < POINTS; p++) begin
         if (xb_ff == xs_ff[p]) key_match = 1'b1;
         for (int r = p + 1; r < POINTS; r++) begin
            if (xs_ff[p] == xs_ff[r]) zero_den = 1'b1;
         end
      end
   end

   // The result fits 32 bits when everything above bit 30 is a copy of the sign.
   assign sat_sign = acc_ff[ACC_W-1];
   assign sat_fit  = (&acc_ff[ACC_W-1:DATA_W-1]) || !(|acc_ff[ACC_W-1:DATA_W-1]);
   assign res_sat  = sat_fit ? acc_ff[DATA_W-1:0] : (sat_sign ? SAT_MIN : SAT_MAX);

   always_comb begin
      table_size_in   = csr_wr_en ? csr_wr_data : table_size_ff;
      last_bracket_in = last_bracket_ff;
      bracket_in      = bracket_ff;
      xb_in   = xb_ff;   key1_in = key1_ff; xi_in  = xi_ff;
      n_in    = n_ff;    lo_in   = lo_ff;   hi_in  = hi_ff;
      inc_in  = inc_ff;  k_in    = k_ff;
      asc_in  = asc_ff;  zd_in   = zd_ff;   neg_in = neg_ff;
      term_in = term_ff; fac_in  = fac_ff;  cnt_in = cnt_ff;
      num_in  = num_ff;  pn_in   = pn_ff;   den_in = den_ff; pd_in = pd_ff;
      fa_in   = fa_ff;   fb_in   = fb_ff;
      dvd_in  = dvd_ff;  dvs_in  = dvs_ff;  rem_in = rem_ff;
      acc_in  = acc_ff;  rsp_in  = rsp_ff;
      for (int p = 0; p < POINTS; p++) begin
         xs_in[p] = xs_ff[p];
         ys_in[p] = ys_ff[p];
      end
      case (cmd.op)
         OP_CAPTURE: begin
            xb_in = req_item.key_value;
            n_in  = n_clamp;
            lo_in = $signed({{(IW-CSR_W){1'b0}}, last_bracket_ff});
         end
         OP_KEY1: key1_in = rd_key;
         OP_ASC: begin
            asc_in = rd_key > key1_ff;
            if (status.stale) begin
               lo_in = '0;
               hi_in = n_ff + ONE_I;
            end
         end
         OP_HUP_START: begin
            hi_in  = lo_ff + ONE_I;
            inc_in = ONE_I;
         end
         OP_HDN_START: begin
            hi_in  = lo_ff;
            lo_in  = lo_ff - ONE_I;
            inc_in = ONE_I;
         end
         OP_HUP_STEP: begin
            lo_in  = hi_ff;
            inc_in = inc_ff <<< 1;
            hi_in  = (hup_next > n_ff) ? n_ff + ONE_I : hup_next;
         end
         OP_HDN_STEP: begin
            hi_in  = lo_ff;
            inc_in = inc_ff <<< 1;
            lo_in  = (hdn_next < ONE_I) ? '0 : hdn_next;
         end
         OP_SET_ZERO: lo_in = '0;
         OP_BIS_STEP: begin
            if (status.bis_right) lo_in = mid;
            else hi_in = mid;
         end
         OP_BRACKET: begin
            last_bracket_in = lo_ff[CSR_W-1:0];
            bracket_in      = lo_ff[CSR_W-1:0];
            if (k_raw < ONE_I) k_in = ONE_I;
            else if (k_raw > n_ff - THREE_I) k_in = n_ff - THREE_I;
            else k_in = k_raw;
            cnt_in = '0;
         end
         OP_FETCH: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff != '0) begin
               for (int p = 0; p < POINTS - 1; p++) begin
                  xs_in[p] = xs_ff[p+1];
                  ys_in[p] = ys_ff[p+1];
               end
               xs_in[POINTS-1] = rd_key;
               ys_in[POINTS-1] = rd_val;
            end
         end
         OP_NUDGE: begin
            // A key that hits a node exactly is moved one step, downward at the top code.
            if (key_match) xb_in = (xb_ff == SAT_MAX) ? xb_ff - 1'b1 : xb_ff + 1'b1;
            zd_in   = zero_den;
            acc_in  = '0;
            term_in = '0;
         end
         OP_TERM_INIT: begin
            xi_in  = xsel;
            num_in = NUM_W'(mag_y);
            neg_in = ysel[DATA_W-1];
            den_in = DEN_W'(1);
            fac_in = '0;
         end
         OP_FACTOR_INIT: begin
            fa_in  = mag_a;
            fb_in  = mag_b;
            neg_in = neg_ff ^ da[DATA_W] ^ db[DATA_W];
            pn_in  = '0;
            pd_in  = '0;
            cnt_in = '0;
         end
         OP_MUL_STEP: begin
            pn_in  = {pn_ff[NUM_W-2:0], 1'b0} + (fa_ff[DATA_W-1] ? num_ff : '0);
            pd_in  = {pd_ff[DEN_W-2:0], 1'b0} + (fb_ff[DATA_W-1] ? den_ff : '0);
            fa_in  = {fa_ff[DATA_W-2:0], 1'b0};
            fb_in  = {fb_ff[DATA_W-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (status.mul_last) begin
               num_in = pn_in;
               den_in = pd_in;
               fac_in = fac_ff + 1'b1;
            end
         end
         OP_DIV_INIT: begin
            // Round half away from zero: floor((2N + D) / 2D).
            dvd_in = {num_ff, 1'b0} + DVD_W'(den_ff);
            dvs_in = {den_ff, 1'b0};
            rem_in = '0;
            cnt_in = '0;
         end
         OP_DIV_STEP: begin
            if (!rem_diff[DVS_W]) begin
               rem_in = rem_diff[DVS_W-1:0];
               dvd_in = {dvd_ff[DVD_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[DVS_W-1:0];
               dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
         end
         OP_ACCUM: begin
            acc_in  = neg_ff ? acc_ff - $signed(q_ext) : acc_ff + $signed(q_ext);
            term_in = term_ff + 1'b1;
         end
         OP_OUT_LOAD: begin
            rsp_in.result_value  = zd_ff ? '0 : res_sat;
            rsp_in.overflow_flag = zd_ff || !sat_fit;
            rsp_in.bracket_index = bracket_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff   <= TABLE_SIZE_RESET;
         last_bracket_ff <= LAST_BRACKET_RESET;
      end else begin
         table_size_ff   <= table_size_in;
         last_bracket_ff <= last_bracket_in;
      end
   end

   always_ff @(posedge clock) begin
      bracket_ff <= bracket_in;
      xb_ff   <= xb_in;   key1_ff <= key1_in; xi_ff  <= xi_in;
      n_ff    <= n_in;    lo_ff   <= lo_in;   hi_ff  <= hi_in;
      inc_ff  <= inc_in;  k_ff    <= k_in;
      asc_ff  <= asc_in;  zd_ff   <= zd_in;   neg_ff <= neg_in;
      term_ff <= term_in; fac_ff  <= fac_in;  cnt_ff <= cnt_in;
      num_ff  <= num_in;  pn_ff   <= pn_in;   den_ff <= den_in; pd_ff <= pd_in;
      fa_ff   <= fa_in;   fb_ff   <= fb_in;
      dvd_ff  <= dvd_in;  dvs_ff  <= dvs_in;  rem_ff <= rem_in;
      acc_ff  <= acc_in;  rsp_ff  <= rsp_in;
      for (int p = 0; p < POINTS; p++) begin
         xs_ff[p] <= xs_in[p];
         ys_ff[p] <= ys_in[p];
      end
   end

   always_comb begin
      status.stale       = (lo_ff < ONE_I) || (lo_ff > n_ff);
      status.hunt_up     = (ge == asc_ff);
      status.hunt_dn     = (!ge == asc_ff);
      status.bis_right   = (gt == asc_ff);
      status.lo_is_n     = (lo_ff == n_ff);
      status.lo_is_one   = (lo_ff == ONE_I);
      status.hup_over    = (hup_next > n_ff);
      status.hdn_under   = (hdn_next < ONE_I);
      status.bis_done    = ((hi_ff - lo_ff) == ONE_I);
      status.fetch_done  = (cnt_ff == CNT_W'(POINTS));
      status.zero_den    = zero_den;
      status.mul_last    = (cnt_ff == CNT_W'(MUL_STEPS - 1));
      status.factor_last = (fac_ff == 2'(POINTS - 2));
      status.div_last    = (cnt_ff == CNT_W'(DVD_W - 1));
      status.term_last   = (term_ff == 2'(POINTS - 1));
   end

   assign rsp_item = rsp_ff;

   a_bracket_in_table: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_BRACKET) |-> (lo_ff >= 0 && lo_ff <= n_ff))
      else $error("bracket outside the table");

   a_bisect_open: assert property (@(posedge clock) disable iff (reset)
      (cmd.addr_sel == ADDR_MID) |-> ((hi_ff - lo_ff) > ONE_I))
      else $error("bisection probe on a closed interval");

   a_fetch_window: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_BRACKET) |=> (k_ff >= ONE_I && (k_ff + THREE_I) <= n_ff))
      else $error("four point window leaves the table");

endmodule

`default_nettype wire

// ===== rtl/four_point_table_interpolator_top.sv =====
// Top level of the four point table interpolator.
// Depends on fpti_pkg, fpti_ctrl, fpti_dp and fpti_ram.
//
// The block keeps a key/value table in signed Q8.24. Items arrive on the req_ channel
// with a valid/stall handshake. A load item writes one entry in the cycle it is
// accepted and gives no result. A query item searches the first table_size entries
// (clamped to 4 to TABLE_DEPTH; hunt from the last bracket, then bisection), fetches
// four neighboring entries and evaluates the cubic Lagrange polynomial through them,
// each term rounded, giving one rsp_ item: saturated value, one based bracket, flag.
// The csr_ port writes table_size; write it only while the block is idle.
// A query sets up, probes the table, fetches the four entries, then evaluates four
// terms with the one-bit-per-cycle shift-add multiplier (three passes per term) and
// the restoring divider that the terms share. A query whose four keys are not
// distinct finishes after the fetch. The result sits in an output register. While
// the receiver stalls it holds, and the block still accepts load items; a further
// query waits at its end for the register. Reset (synchronous) sets table_size to 4
// and the remembered bracket to 1; table contents are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module four_point_table_interpolator_top #(
   parameter int TABLE_DEPTH = fpti_pkg::DEFAULT_TABLE_DEPTH
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire fpti_pkg::req_item_type     req_item,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output fpti_pkg::rsp_item_type          rsp_item,
   input  wire logic                       csr_wr_en,
   input  wire logic [fpti_pkg::CSR_W-1:0] csr_wr_data
);
   import fpti_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // The controller only sequences; all arithmetic and table storage sit in the datapath.
   fpti_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_item.req_type),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   fpti_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_item    (req_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .status      (status),
      .rsp_item    (rsp_item)
   );

endmodule

`default_nettype wire

// ===== verif/four_point_table_interpolator_top_tb.sv =====
// Self-checking testbench for the four point table interpolator.
// Depends on fpti_pkg and four_point_table_interpolator_top, and through it on the other design files.
// An initial block queues table loads and queries and writes table_size; a clocked
// driver offers the items, a clocked monitor stalls at random and checks every result.
`timescale 1ns / 1ps

module four_point_table_interpolator_top_tb;
   import fpti_pkg::*;

   localparam int DEPTH = DEFAULT_TABLE_DEPTH;
   localparam int ITEM_GOAL = 1500;
   localparam longint CYCLE_LIMIT = 6_000_000;
   localparam int HOLD_CYCLES = 4000;
   localparam longint KEY_MAX = 64'sh7FFF_FFFF;
   localparam longint KEY_MIN = -64'sh8000_0000;

   typedef logic signed [199:0] wide_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_item_type req_item = '0;
   logic rsp_valid;
   logic rsp_stall;
   rsp_item_type rsp_item;
   logic csr_wr_en = 1'b0;
   logic [CSR_W-1:0] csr_wr_data = '0;

   // Items waiting to be offered, and results the predictor has worked out.
   req_item_type pending_items[$];
   rsp_item_type expected_results[$];

   // The predictor's own copy of the block state.
   longint key_mem[DEPTH];
   longint value_mem[DEPTH];
   int bracket_mem;
   int size_reg;

   int error_count = 0;
   int results_seen = 0;
   int items_queued = 0;
   bit sender_fast = 1'b0;
   longint cycle_count = 0;

   four_point_table_interpolator_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #10 clock = ~clock;

   // Hunt from the remembered bracket with a doubling step, then bisect.
   function automatic int find_bracket(longint x, int n, int start);
      bit asc;
      int lo, hi, mid, inc;
      asc = key_mem[n-1] > key_mem[0];
      lo = start;
      if (lo <= 0 || lo > n) begin
         lo = 0;
         hi = n + 1;
      end else begin
         inc = 1;
         if ((x >= key_mem[lo-1]) == asc) begin
            if (lo == n) return lo;
            hi = lo + 1;
            while ((x >= key_mem[hi-1]) == asc) begin
               lo = hi;
               inc += inc;
               hi = lo + inc;
               if (hi > n) begin
                  hi = n + 1;
                  break;
               end
            end
         end else begin
            if (lo == 1) return 0;
            hi = lo;
            lo -= 1;
            while ((x < key_mem[lo-1]) == asc) begin
               hi = lo;
               inc += inc;
               lo = hi - inc;
               if (lo < 1) begin
                  lo = 0;
                  break;
               end
            end
         end
      end
      while (hi - lo != 1) begin
         mid = (hi + lo) >> 1;
         if ((x > key_mem[mid-1]) == asc) lo = mid;
         else hi = mid;
      end
      return lo;
   endfunction

   // Cubic Lagrange value through four neighbors, each term rounded half away
   // from zero, the exact sum saturated to 32 bits.
   function automatic rsp_item_type interpolate(longint key);
      rsp_item_type r;
      longint xs[4], ys[4], xb;
      wide_t num, den, q, acc;
      int n, k;
      bit dup, neg;
      n = size_reg;
      if (n > DEPTH) n = DEPTH;
      if (n < MIN_TABLE_SIZE) n = MIN_TABLE_SIZE;
      bracket_mem = find_bracket(key, n, bracket_mem);
      k = bracket_mem - 1;
      if (k < 1) k = 1;
      if (k > n - 3) k = n - 3;
      for (int i = 0; i < 4; i++) begin
         xs[i] = key_mem[k-1+i];
         ys[i] = value_mem[k-1+i];
      end
      xb = key;
      if (xb == xs[0] || xb == xs[1] || xb == xs[2] || xb == xs[3])
         xb = (xb == KEY_MAX) ? xb - 1 : xb + 1;
      dup = 1'b0;
      for (int i = 0; i < 4; i++)
         for (int j = 0; j < 4; j++)
            if (i != j && xs[i] == xs[j]) dup = 1'b1;
      r.bracket_index = bracket_mem[CSR_W-1:0];
      if (dup) begin
         r.result_value = '0;
         r.overflow_flag = 1'b1;
         return r;
      end
      acc = '0;
      for (int i = 0; i < 4; i++) begin
         num = wide_t'(ys[i]);
         den = 1;
         for (int j = 0; j < 4; j++) begin
            if (j != i) begin
               num = num * wide_t'(xb - xs[j]);
               den = den * wide_t'(xs[i] - xs[j]);
            end
         end
         neg = (num < 0) ^ (den < 0);
         if (num < 0) num = -num;
         if (den < 0) den = -den;
         q = (2 * num + den) / (2 * den);
         acc = neg ? acc - q : acc + q;
      end
      r.overflow_flag = 1'b0;
      if (acc > wide_t'(KEY_MAX)) begin
         r.result_value = SAT_MAX;
         r.overflow_flag = 1'b1;
      end else if (acc < wide_t'(KEY_MIN)) begin
         r.result_value = SAT_MIN;
         r.overflow_flag = 1'b1;
      end else begin
         r.result_value = acc[DATA_W-1:0];
      end
      return r;
   endfunction

   // Driver: a load updates the table copy at acceptance, a query is predicted
   // at acceptance, so the predictor sees the items in the block's own order.
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            if (req_item.req_type == REQ_LOAD) begin
               key_mem[req_item.entry_index] = longint'(req_item.key_value);
               value_mem[req_item.entry_index] = longint'(req_item.entry_value);
            end else begin
               expected_results.push_back(interpolate(longint'(req_item.key_value)));
            end
         end
         // A stalled item stays on the port unchanged.
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               req_item <= pending_items.pop_front();
               req_valid <= 1'b1;
               gap_left <= sender_fast ? 0 : $urandom_range(0, 14);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: each result draws its own stall time.
   int stall_left = 0;
   logic rand_stall = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rand_stall <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               $error("result with nothing expected: value %0d", rsp_item.result_value);
               error_count++;
            end else begin
               rsp_item_type want;
               want = expected_results.pop_front();
               if (rsp_item.result_value !== want.result_value) begin
                  $error("result_value: expected %0d, actual %0d",
                         want.result_value, rsp_item.result_value);
                  error_count++;
               end
               if (rsp_item.bracket_index !== want.bracket_index) begin
                  $error("bracket_index: expected %0d, actual %0d",
                         want.bracket_index, rsp_item.bracket_index);
                  error_count++;
               end
               if (rsp_item.overflow_flag !== want.overflow_flag) begin
                  $error("overflow_flag: expected %0d, actual %0d",
                         want.overflow_flag, rsp_item.overflow_flag);
                  error_count++;
               end
            end
            if ($urandom_range(0, 3) == 0) begin
               stall_left <= 0;
               rand_stall <= 1'b0;
            end else begin
               stall_left <= $urandom_range(0, 14);
               rand_stall <= 1'b1;
            end
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rand_stall <= (stall_left > 1);
         end else begin
            rand_stall <= 1'b0;
         end
      end
   end

   // Once, early on, the receiver holds off for a long stretch so that the
   // block backs up while the sender keeps offering items.
   int hold_left = 0;
   bit held_long = 1'b0;
   logic hold_stall = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_stall <= 1'b0;
      end else if (!held_long && results_seen >= 30) begin
         held_long <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         hold_stall <= (hold_left > 1);
      end else begin
         hold_stall <= 1'b0;
      end
   end

   assign rsp_stall = rand_stall || hold_stall;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("four_point_table_interpolator_top_tb: errors");
         $finish;
      end
   end

   task automatic queue_load(int index, longint key, longint value);
      req_item_type it;
      it.req_type = REQ_LOAD;
      it.entry_index = index[ENTRY_W-1:0];
      it.key_value = key[DATA_W-1:0];
      it.entry_value = value[DATA_W-1:0];
      pending_items.push_back(it);
      items_queued++;
   endtask

   // Query items carry random bits in the fields the block ignores.
   task automatic queue_query(longint key);
      req_item_type it;
      it.req_type = REQ_QUERY;
      it.entry_index = ENTRY_W'($urandom);
      it.key_value = key[DATA_W-1:0];
      it.entry_value = DATA_W'($urandom);
      pending_items.push_back(it);
      items_queued++;
   endtask

   // Wait until every item is taken and every result is back, then let the
   // block settle before the register may be touched.
   task automatic wait_idle();
      while (pending_items.size() > 0 || req_valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_size(int value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value[CSR_W-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      size_reg = value;
   endtask

   function automatic longint random_key();
      return longint'($signed($urandom));
   endfunction

   function automatic longint random_value();
      if ($urandom_range(0, 2) == 0) return longint'($signed($urandom));
      return longint'($signed($urandom) >>> $urandom_range(8, 30));
   endfunction

   // Builds and loads a table of the given length. Shapes: ascending over the
   // whole key range, ascending with small steps, either one reversed, with a
   // repeated key, or unordered.
   task automatic load_table(int n, int shape, ref longint keys[$]);
      longint base, step;
      int dup_at;
      keys.delete();
      if (shape == 0 || shape == 1) begin
         for (int i = 0; i < n; i++) keys.push_back(random_key());
         keys.sort();
      end else if (shape == 5) begin
         for (int i = 0; i < n; i++) keys.push_back(random_key());
      end else begin
         step = $urandom_range(1, 1 << $urandom_range(0, 20));
         base = longint'($urandom_range(0, 32'hE000_0000)) - 64'sh8000_0000;
         for (int i = 0; i < n; i++) keys.push_back(base + i * step);
      end
      if (shape == 1 || shape == 3) keys.reverse();
      if (shape == 4) begin
         dup_at = $urandom_range(0, n - 2);
         keys[dup_at + 1] = keys[dup_at];
      end
      for (int i = 0; i < n; i++) queue_load(i, keys[i], random_value());
   endtask

   initial begin
      longint keys[$];
      int n, picked, shape, setting;
      for (int i = 0; i < DEPTH; i++) begin
         key_mem[i] = 0;
         value_mem[i] = 0;
      end
      bracket_mem = LAST_BRACKET_RESET;
      size_reg = TABLE_SIZE_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Every entry is written first, so no query ever reads an unwritten one.
      load_table(DEPTH, 2, keys);

      // Directed: a four-entry table spanning the key range with extreme
      // values; exact hits on every key, and keys in the gaps between them.
      queue_load(0, KEY_MIN, 64'sh7FFF_FFFF);
      queue_load(1, -5, KEY_MIN);
      queue_load(2, 7, 1);
      queue_load(3, KEY_MAX, -1);
      queue_query(KEY_MAX);
      queue_query(KEY_MIN);
      queue_query(-5);
      queue_query(7);
      queue_query(0);
      queue_query(-64'sh4000_0000);
      queue_query(64'sh4000_0000);
      // Small table with repeated keys gives a zero denominator.
      queue_load(1, 7, 100);
      queue_query(3);
      queue_query(KEY_MAX);
      queue_load(1, -5, 100);
      queue_query(1);
      wait_idle();

      // Register settings: extremes first, below and above the clamp, then random.
      setting = 0;
      while (items_queued < ITEM_GOAL) begin
         case (setting)
            0: n = 256;
            1: n = 4;
            2: n = 0;
            3: n = 511;
            4: n = 3;
            5: n = 257;
            default: n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511)
                                                      : $urandom_range(4, 12);
         endcase
         setting++;
         write_size(n);
         if (n > DEPTH) n = DEPTH;
         if (n < MIN_TABLE_SIZE) n = MIN_TABLE_SIZE;
         sender_fast = ($urandom_range(0, 3) == 0);
         shape = (setting % 3 == 0) ? 2 : $urandom_range(0, 5);
         load_table(n, shape, keys);
         for (int q = 0; q < 10; q++) begin
            picked = $urandom_range(0, n - 1);
            case ($urandom_range(0, 5))
               0: queue_query(keys[picked]);
               1: queue_query(random_key());
               2: queue_query(($urandom_range(0, 1) == 1) ? KEY_MAX : KEY_MIN);
               default: begin
                  // Between two neighbors, inside the table.
                  if (picked == n - 1) picked--;
                  queue_query((keys[picked] + keys[picked+1]) / 2);
               end
            endcase
            // Now and then a load lands between queries.
            if ($urandom_range(0, 4) == 0) queue_load(picked, keys[picked], random_value());
         end
         wait_idle();
      end

      repeat (50) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("four_point_table_interpolator_top_tb: clean");
      end else begin
         $display("four_point_table_interpolator_top_tb: errors");
      end
      $finish;
   end

endmodule
